[hdl/first_fit_hole_allocator_assert.svh]
// Assertion macros used by the allocator checker.
`ifndef FIRST_FIT_HOLE_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_HOLE_ALLOCATOR_ASSERT_SVH

// Check that post holds in the cycle after pre.
`define FFHA_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("ffha: next-cycle check failed");

// Check that post holds in the same cycle as pre.
`define FFHA_ASSERT_NOW(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("ffha: same-cycle check failed");

`endif

[hdl/ffha_pkg.sv]
// Shared constants, codes and control types of the first-fit hole allocator.
`default_nettype none
package ffha_pkg;

    localparam int ADDR_BITS         = 16;
    localparam int DEF_TABLE_ENTRIES = 128;
    localparam logic [ADDR_BITS-1:0] MEM_CLICKS_RESET = 16'd4096;

    localparam logic [1:0] REQ_ALLOC = 2'd0;
    localparam logic [1:0] REQ_FREE  = 2'd1;
    localparam logic [1:0] REQ_INIT  = 2'd2;
    localparam logic [1:0] REQ_NONE  = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NO_MEM = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_CLR,
        CMD_START,
        CMD_A_HEAD,
        CMD_A_CHK,
        CMD_A_DROP,
        CMD_F_SP_RD,
        CMD_F_TAKE,
        CMD_F_HEAD,
        CMD_F_WALK,
        CMD_F_INS,
        CMD_F_LINK,
        CMD_M_RD,
        CMD_M_H,
        CMD_M_N,
        CMD_M_DROP,
        CMD_L_RD,
        CMD_L_CHK,
        CMD_OUT
    } cmd_t;

    typedef struct packed {
        logic list_ok;
        logic spare_ok;
        logic rd_ok;
        logic fit;
        logic used_up;
        logic base_le;
        logic touch;
        logic second;
        logic clr_last;
        logic out_free;
    } dp_flags_t;

endpackage
`default_nettype wire

[hdl/ffha_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ffha_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

[hdl/ffha_ctrl.sv]
// Sequencer of the hole allocator: walks each request through its steps.
`default_nettype none
module ffha_ctrl
    import ffha_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  logic [1:0] req_type,
    input  dp_flags_t flags,
    output cmd_t      cmd
);

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_A_HEAD, S_A_CHK, S_A_DROP, S_F_SP_RD, S_F_TAKE,
        S_F_HEAD, S_F_WALK, S_F_INS, S_F_LINK, S_M_RD, S_M_H, S_M_N,
        S_M_DROP, S_L_RD, S_L_CHK, S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   init_req_reg, init_req_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        init_req_next = init_req_reg;
        cmd           = CMD_NONE;
        case (state_reg)
            S_CLR:
            begin
                cmd = CMD_CLR;
                if (flags.clr_last)
                begin
                    state_next    = init_req_reg ? S_L_RD : S_IDLE;
                    init_req_next = 1'b0;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd = CMD_START;
                    case (req_type)
                        REQ_ALLOC: state_next = S_A_HEAD;
                        REQ_FREE:  state_next = S_F_SP_RD;
                        REQ_INIT:
                        begin
                            state_next    = S_CLR;
                            init_req_next = 1'b1;
                        end
                        default:   state_next = S_L_RD;
                    endcase
                end
            end
            S_A_HEAD:
            begin
                cmd        = CMD_A_HEAD;
                state_next = flags.list_ok ? S_A_CHK : S_L_RD;
            end
            S_A_CHK:
            begin
                cmd = CMD_A_CHK;
                if (flags.fit)
                begin
                    state_next = flags.used_up ? S_A_DROP : S_L_RD;
                end
                else
                begin
                    state_next = flags.rd_ok ? S_A_CHK : S_L_RD;
                end
            end
            S_A_DROP:
            begin
                cmd        = CMD_A_DROP;
                state_next = S_L_RD;
            end
            S_F_SP_RD:
            begin
                cmd        = CMD_F_SP_RD;
                state_next = flags.spare_ok ? S_F_TAKE : S_L_RD;
            end
            S_F_TAKE:
            begin
                cmd        = CMD_F_TAKE;
                state_next = S_F_HEAD;
            end
            S_F_HEAD:
            begin
                cmd = CMD_F_HEAD;
                if (!flags.list_ok || flags.base_le)
                begin
                    state_next = S_M_RD;
                end
                else
                begin
                    state_next = flags.rd_ok ? S_F_WALK : S_F_INS;
                end
            end
            S_F_WALK:
            begin
                cmd        = CMD_F_WALK;
                state_next = (!flags.base_le && flags.rd_ok) ? S_F_WALK : S_F_INS;
            end
            S_F_INS:
            begin
                cmd        = CMD_F_INS;
                state_next = S_F_LINK;
            end
            S_F_LINK:
            begin
                cmd        = CMD_F_LINK;
                state_next = S_M_RD;
            end
            S_M_RD:
            begin
                cmd        = CMD_M_RD;
                state_next = S_M_H;
            end
            S_M_H:
            begin
                cmd        = CMD_M_H;
                state_next = flags.rd_ok ? S_M_N : S_L_RD;
            end
            S_M_N:
            begin
                cmd = CMD_M_N;
                if (flags.touch)
                begin
                    state_next = S_M_DROP;
                end
                else
                begin
                    state_next = flags.second ? S_L_RD : S_M_RD;
                end
            end
            S_M_DROP:
            begin
                cmd        = CMD_M_DROP;
                state_next = flags.second ? S_L_RD : S_M_RD;
            end
            S_L_RD:
            begin
                cmd        = CMD_L_RD;
                state_next = flags.list_ok ? S_L_CHK : S_OUT;
            end
            S_L_CHK:
            begin
                cmd        = CMD_L_CHK;
                state_next = flags.rd_ok ? S_L_CHK : S_OUT;
            end
            S_OUT:
            begin
                if (flags.out_free)
                begin
                    cmd        = CMD_OUT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLR;
            init_req_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            init_req_reg <= init_req_next;
        end
    end

endmodule
`default_nettype wire

[hdl/ffha_dp.sv]
// Datapath of the hole allocator: hole table memories, list pointers, result register.
`default_nettype none
module ffha_dp
    import ffha_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cmd_t                 cmd,
    output dp_flags_t            flags,
    input  logic [ADDR_BITS-1:0] in_base,
    input  logic [ADDR_BITS-1:0] in_clicks,
    input  logic                 cfg_valid,
    input  logic [ADDR_BITS-1:0] cfg_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [1:0]           out_status,
    output logic [ADDR_BITS-1:0] out_alloc_base,
    output logic [ADDR_BITS-1:0] out_largest
);

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int LW = IW + 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);
    localparam logic [IW-1:0] FIRST_SPARE = IW'(1);
    localparam logic [ADDR_BITS-1:0] ALL_ONES = {ADDR_BITS{1'b1}};

    // control state
    logic                 list_ok_reg, list_ok_next;
    logic                 spare_ok_reg, spare_ok_next;
    logic                 out_valid_reg, out_valid_next;
    logic [IW-1:0]        clr_idx_reg, clr_idx_next;
    logic [ADDR_BITS-1:0] mem_clicks_reg;

    // payload
    logic [IW-1:0]        list_head_reg, list_head_next;
    logic [IW-1:0]        spare_head_reg, spare_head_next;
    logic [IW-1:0]        cur_reg, cur_next;
    logic [IW-1:0]        prev_reg, prev_next;
    logic                 has_prev_reg, has_prev_next;
    logic [LW-1:0]        prev_lnk_reg, prev_lnk_next;
    logic [IW-1:0]        fresh_reg, fresh_next;
    logic [IW-1:0]        h_reg, h_next;
    logic [IW-1:0]        n_reg, n_next;
    logic [ADDR_BITS-1:0] hs_reg, hs_next;
    logic [ADDR_BITS-1:0] hl_reg, hl_next;
    logic                 second_reg, second_next;
    logic [ADDR_BITS-1:0] base_reg, base_next;
    logic [ADDR_BITS-1:0] clicks_reg, clicks_next;
    logic [1:0]           status_reg, status_next;
    logic [ADDR_BITS-1:0] got_reg, got_next;
    logic [ADDR_BITS-1:0] best_reg, best_next;
    logic [1:0]           ostat_reg, ostat_next;
    logic [ADDR_BITS-1:0] obase_reg, obase_next;
    logic [ADDR_BITS-1:0] olarge_reg, olarge_next;

    // memory ports
    logic                 st_we, ln_we, lk_we;
    logic [IW-1:0]        st_wa, ln_wa, lk_wa, raddr;
    logic [ADDR_BITS-1:0] st_wd, ln_wd, rd_start, rd_len;
    logic [LW-1:0]        lk_wd, rd_lnk;
    logic                 rd_ok;
    logic [IW-1:0]        rd_link;
    logic [ADDR_BITS:0]   end_sum, len_sum;

    assign rd_ok   = rd_lnk[IW];
    assign rd_link = rd_lnk[IW-1:0];
    assign end_sum = {1'b0, hs_reg} + {1'b0, hl_reg};
    assign len_sum = {1'b0, hl_reg} + {1'b0, rd_len};

    assign flags.list_ok  = list_ok_reg;
    assign flags.spare_ok = spare_ok_reg;
    assign flags.rd_ok    = rd_ok;
    assign flags.fit      = (rd_len >= clicks_reg);
    assign flags.used_up  = (rd_len == clicks_reg);
    assign flags.base_le  = (base_reg <= rd_start);
    assign flags.touch    = (end_sum == {1'b0, rd_start});
    assign flags.second   = second_reg;
    assign flags.clr_last = (clr_idx_reg == LAST_IDX);
    assign flags.out_free = !out_valid_reg || out_ready;

    ffha_ram #(.WIDTH(ADDR_BITS), .DEPTH(TABLE_ENTRIES)) u_start (
        .clk(clk), .we(st_we), .waddr(st_wa), .wdata(st_wd),
        .raddr(raddr), .rdata(rd_start)
    );

    ffha_ram #(.WIDTH(ADDR_BITS), .DEPTH(TABLE_ENTRIES)) u_len (
        .clk(clk), .we(ln_we), .waddr(ln_wa), .wdata(ln_wd),
        .raddr(raddr), .rdata(rd_len)
    );

    ffha_ram #(.WIDTH(LW), .DEPTH(TABLE_ENTRIES)) u_link (
        .clk(clk), .we(lk_we), .waddr(lk_wa), .wdata(lk_wd),
        .raddr(raddr), .rdata(rd_lnk)
    );

    always_comb
    begin
        list_ok_next    = list_ok_reg;
        spare_ok_next   = spare_ok_reg;
        clr_idx_next    = clr_idx_reg;
        list_head_next  = list_head_reg;
        spare_head_next = spare_head_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        has_prev_next   = has_prev_reg;
        prev_lnk_next   = prev_lnk_reg;
        fresh_next      = fresh_reg;
        h_next          = h_reg;
        n_next          = n_reg;
        hs_next         = hs_reg;
        hl_next         = hl_reg;
        second_next     = second_reg;
        base_next       = base_reg;
        clicks_next     = clicks_reg;
        status_next     = status_reg;
        got_next        = got_reg;
        best_next       = best_reg;
        ostat_next      = ostat_reg;
        obase_next      = obase_reg;
        olarge_next     = olarge_reg;
        out_valid_next  = out_ready ? 1'b0 : out_valid_reg;
        st_we = 1'b0; st_wa = '0; st_wd = '0;
        ln_we = 1'b0; ln_wa = '0; ln_wd = '0;
        lk_we = 1'b0; lk_wa = '0; lk_wd = '0;
        raddr = '0;
        case (cmd)
            CMD_CLR:
            begin
                // rebuild one entry per cycle; slot 0 holds the whole memory
                st_we = 1'b1; st_wa = clr_idx_reg; st_wd = '0;
                ln_we = 1'b1; ln_wa = clr_idx_reg;
                ln_wd = (clr_idx_reg == '0) ? mem_clicks_reg : '0;
                lk_we = 1'b1; lk_wa = clr_idx_reg;
                lk_wd = {(clr_idx_reg != '0) && (clr_idx_reg != LAST_IDX),
                         clr_idx_reg + FIRST_SPARE};
                clr_idx_next    = (clr_idx_reg == LAST_IDX) ? '0 : clr_idx_reg + FIRST_SPARE;
                list_head_next  = '0;
                list_ok_next    = 1'b1;
                spare_head_next = FIRST_SPARE;
                spare_ok_next   = 1'b1;
                status_next     = ST_OK;
                got_next        = '0;
            end
            CMD_START:
            begin
                base_next   = in_base;
                clicks_next = in_clicks;
                status_next = ST_OK;
                got_next    = '0;
            end
            CMD_A_HEAD:
            begin
                raddr         = list_head_reg;
                cur_next      = list_head_reg;
                has_prev_next = 1'b0;
                if (!list_ok_reg)
                begin
                    status_next = ST_NO_MEM;
                end
            end
            CMD_A_CHK:
            begin
                if (rd_len >= clicks_reg)
                begin
                    got_next = rd_start;
                    st_we = 1'b1; st_wa = cur_reg; st_wd = rd_start + clicks_reg;
                    ln_we = 1'b1; ln_wa = cur_reg; ln_wd = rd_len - clicks_reg;
                    if (rd_len == clicks_reg)
                    begin
                        if (!has_prev_reg)
                        begin
                            list_head_next = rd_link;
                            list_ok_next   = rd_ok;
                        end
                        else
                        begin
                            lk_we = 1'b1; lk_wa = prev_reg; lk_wd = rd_lnk;
                        end
                    end
                end
                else
                begin
                    prev_next     = cur_reg;
                    has_prev_next = 1'b1;
                    cur_next      = rd_link;
                    raddr         = rd_link;
                    if (!rd_ok)
                    begin
                        status_next = ST_NO_MEM;
                    end
                end
            end
            CMD_A_DROP:
            begin
                lk_we = 1'b1; lk_wa = cur_reg; lk_wd = {spare_ok_reg, spare_head_reg};
                spare_head_next = cur_reg;
                spare_ok_next   = 1'b1;
            end
            CMD_F_SP_RD:
            begin
                raddr = spare_head_reg;
                if (!spare_ok_reg)
                begin
                    status_next = ST_FULL;
                end
            end
            CMD_F_TAKE:
            begin
                fresh_next      = spare_head_reg;
                spare_head_next = rd_link;
                spare_ok_next   = rd_ok;
                st_we = 1'b1; st_wa = spare_head_reg; st_wd = base_reg;
                ln_we = 1'b1; ln_wa = spare_head_reg; ln_wd = clicks_reg;
                raddr = list_head_reg;
            end
            CMD_F_HEAD:
            begin
                if (!list_ok_reg || (base_reg <= rd_start))
                begin
                    lk_we = 1'b1; lk_wa = fresh_reg; lk_wd = {list_ok_reg, list_head_reg};
                    list_head_next = fresh_reg;
                    list_ok_next   = 1'b1;
                    h_next         = fresh_reg;
                    second_next    = 1'b0;
                end
                else
                begin
                    prev_next     = list_head_reg;
                    prev_lnk_next = rd_lnk;
                    cur_next      = rd_link;
                    raddr         = rd_link;
                end
            end
            CMD_F_WALK:
            begin
                if (base_reg > rd_start)
                begin
                    prev_next     = cur_reg;
                    prev_lnk_next = rd_lnk;
                    cur_next      = rd_link;
                    raddr         = rd_link;
                end
            end
            CMD_F_INS:
            begin
                lk_we = 1'b1; lk_wa = fresh_reg; lk_wd = prev_lnk_reg;
            end
            CMD_F_LINK:
            begin
                lk_we = 1'b1; lk_wa = prev_reg; lk_wd = {1'b1, fresh_reg};
                h_next      = prev_reg;
                second_next = 1'b0;
            end
            CMD_M_RD:
            begin
                raddr = h_reg;
            end
            CMD_M_H:
            begin
                hs_next = rd_start;
                hl_next = rd_len;
                n_next  = rd_link;
                raddr   = rd_link;
            end
            CMD_M_N:
            begin
                if (end_sum == {1'b0, rd_start})
                begin
                    // absorb the upper neighbor, saturating the length
                    ln_we = 1'b1; ln_wa = h_reg;
                    ln_wd = len_sum[ADDR_BITS] ? ALL_ONES : len_sum[ADDR_BITS-1:0];
                    lk_we = 1'b1; lk_wa = h_reg; lk_wd = rd_lnk;
                end
                else
                begin
                    h_next      = n_reg;
                    second_next = 1'b1;
                end
            end
            CMD_M_DROP:
            begin
                lk_we = 1'b1; lk_wa = n_reg; lk_wd = {spare_ok_reg, spare_head_reg};
                spare_head_next = n_reg;
                spare_ok_next   = 1'b1;
                second_next     = 1'b1;
            end
            CMD_L_RD:
            begin
                raddr     = list_head_reg;
                best_next = '0;
            end
            CMD_L_CHK:
            begin
                if (rd_len > best_reg)
                begin
                    best_next = rd_len;
                end
                raddr = rd_link;
            end
            CMD_OUT:
            begin
                out_valid_next = 1'b1;
                ostat_next     = status_reg;
                obase_next     = got_reg;
                olarge_next    = best_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            list_ok_reg    <= 1'b0;
            spare_ok_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            clr_idx_reg    <= '0;
            mem_clicks_reg <= MEM_CLICKS_RESET;
        end
        else
        begin
            list_ok_reg   <= list_ok_next;
            spare_ok_reg  <= spare_ok_next;
            out_valid_reg <= out_valid_next;
            clr_idx_reg   <= clr_idx_next;
            if (cfg_valid)
            begin
                mem_clicks_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        list_head_reg  <= list_head_next;
        spare_head_reg <= spare_head_next;
        cur_reg        <= cur_next;
        prev_reg       <= prev_next;
        has_prev_reg   <= has_prev_next;
        prev_lnk_reg   <= prev_lnk_next;
        fresh_reg      <= fresh_next;
        h_reg          <= h_next;
        n_reg          <= n_next;
        hs_reg         <= hs_next;
        hl_reg         <= hl_next;
        second_reg     <= second_next;
        base_reg       <= base_next;
        clicks_reg     <= clicks_next;
        status_reg     <= status_next;
        got_reg        <= got_next;
        best_reg       <= best_next;
        ostat_reg      <= ostat_next;
        obase_reg      <= obase_next;
        olarge_reg     <= olarge_next;
    end

    assign out_valid      = out_valid_reg;
    assign out_status     = ostat_reg;
    assign out_alloc_base = obase_reg;
    assign out_largest    = olarge_reg;

endmodule
`default_nettype wire

[hdl/first_fit_hole_allocator.sv]
// Top level of the first-fit hole allocator with coalescing.
//
//  channel   | dir | handshake              | payload
//  ----------+-----+------------------------+-------------------------------------
//  s_axis    | in  | s_axis_tvalid/tready   | tuser: req_type; tdata: base, clicks
//  m_axis    | out | m_axis_tvalid/tready   | tuser: status; tdata: alloc_base, largest
//  cfg       | in  | cfg_valid/cfg_ready    | cfg_data: memory_clicks
//
// One request is in flight at a time. Allocate reads the list head and checks the
// holes in turn; free takes a spare slot, walks to its place in the list and merges
// it with its neighbors; every request then walks the whole hole list once more for
// the largest hole, so the worst case is set by the single read port of the table.
// After reset, and for an init request, a rebuild sweep writes one table slot per
// cycle; no request is taken during the reset sweep.
// A result waits in the output register while the next request is accepted.
`default_nettype none
module first_fit_hole_allocator
    import ffha_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] block_base, [31:16] block_clicks
    input  logic [1:0]  s_axis_tuser,   // [1:0] req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [15:0] alloc_base, [31:16] largest_hole
    output logic [1:0]  m_axis_tuser,   // [1:0] status
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data        // memory_clicks
);

    cmd_t      cmd;
    dp_flags_t flags;

    // the size register takes a transfer in any cycle
    assign cfg_ready = 1'b1;

    ffha_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .req_type (s_axis_tuser),
        .flags    (flags),
        .cmd      (cmd)
    );

    ffha_dp #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .flags          (flags),
        .in_base        (s_axis_tdata[15:0]),
        .in_clicks      (s_axis_tdata[31:16]),
        .cfg_valid      (cfg_valid),
        .cfg_data       (cfg_data),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .out_status     (m_axis_tuser),
        .out_alloc_base (m_axis_tdata[15:0]),
        .out_largest    (m_axis_tdata[31:16])
    );

endmodule
`default_nettype wire

[hdl/ffha_checker.sv]
// Port-level checks of the hole allocator, bound to the top level.
`default_nettype none
`include "first_fit_hole_allocator_assert.svh"
module ffha_checker
    import ffha_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    `FFHA_ASSERT_NEXT(a_busy_after_take, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `FFHA_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    `FFHA_ASSERT_NOW(a_fail_base_zero, m_axis_tvalid && (m_axis_tuser != ST_OK), m_axis_tdata[15:0] == 16'd0)
    `FFHA_ASSERT_NOW(a_status_code, m_axis_tvalid, m_axis_tuser <= ST_FULL)

endmodule

bind first_fit_hole_allocator ffha_checker u_ffha_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
